### design/pwg_pkg.sv
// Shared constants, types and the quarter-wave sine table of the waveform generator.
`timescale 1ns / 1ps
package pwg_pkg;

  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int PHASE_W     = 14;
  localparam int SAMPLE_W    = 8;
  localparam int MIN_TONE_HZ = 100;
  localparam int SINE_DEPTH  = 256;
  localparam int SINE_AW     = $clog2(SINE_DEPTH);
  localparam int SINE_VAL_W  = 7;
  localparam int PERIOD_MAX  = (1 << PHASE_W) - 1;
  localparam int MIDSCALE    = 128;

  // The dividend must hold the sine phase scaled by four table lengths and the ramp numerators.
  localparam int SINE_DVD_W  = PHASE_W + SINE_AW + 2;
  localparam int DVD_W       = (SINE_DVD_W > 24) ? SINE_DVD_W : 24;
  localparam int DIV_W       = CFG_W;

  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_TONE_FREQ   = 2'd1,
    REG_WAVEFORM    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_t;

  typedef logic [SINE_VAL_W-1:0] sine_rom_t [0:SINE_DEPTH];

  // Shift-and-subtract long division used while the sine table is built.
  function automatic longint unsigned table_div(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (64'd1 << b);
      end
    end
    return quo;
  endfunction

  // Fixed-point Taylor series in Q30, rounded to 127 full scale.
  function automatic logic [SINE_VAL_W-1:0] quarter_sine(int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned s;
    longint unsigned v;
    x = (longint'(k) * Q30_HALF_PI) / SINE_DEPTH;
    term = x;
    pos = x;
    neg = 0;
    for (int n = 1; n <= 10; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = table_div(term, 64'((2 * n) * (2 * n + 1)));
      if ((n & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    v = (64'd127 * s + (64'd1 << 29)) >> 30;
    if (v > 64'd127) begin
      v = 64'd127;
    end
    return v[SINE_VAL_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      rom[k] = quarter_sine(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### design/pwg_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module pwg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pwg_pkg::DVD_W-1:0]  dividend,
  input  logic [pwg_pkg::DIV_W-1:0]  divisor,
  output logic                       done,
  output logic [pwg_pkg::DVD_W-1:0]  quotient
);
  import pwg_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W-1:0] rem_next;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             q_bit;
  logic [CNT_W-1:0] count;
  logic             busy;

  always_comb begin
    shifted = {rem, quo[DVD_W-1]};
    diff    = shifted - {1'b0, dsr};
    if (shifted >= {1'b0, dsr}) begin
      q_bit    = 1'b1;
      rem_next = diff[DIV_W-1:0];
    end else begin
      q_bit    = 1'b0;
      rem_next = shifted[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DVD_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The divisor is held for the whole division, since the caller may move on.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], q_bit};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

### design/periodic_waveform_generator.sv
// Top level of the periodic waveform generator: registers, sequencer and wave shaping.
//
//   port group          | direction | handshake
//   --------------------+-----------+-------------------------------------------
//   cfg_*               | in        | write when cfg_write_en is high, no wait
//   in_* restart_phase  | in        | in_valid / in_ready
//   out_* sample fields | out       | out_valid / out_ready
//
// Sine, triangle and saw items pass from the accept in S_IDLE through S_PHASE, which picks
// the phase, S_LOAD, which loads the shared divider, and S_DIV (one quotient bit per cycle
// over a 24-bit dividend, then done) to S_OUT, which passes it to the output register.
// Square items skip the divider and go from S_LOAD to S_OUT; items with an invalid tone go
// from S_PHASE to S_OUT. A register write recomputes the period in the same divider:
// in_ready stays low through S_RCALC and S_RWAIT with a valid tone and S_RCALC otherwise.
// Reset is synchronous and clears all control state; there is no clearing pass.
// A finished item waits in the output register while the next item is accepted; the next
// item then waits in S_OUT for as long as the output stays unaccepted.
`timescale 1ns / 1ps
module periodic_waveform_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [pwg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwg_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            restart_phase,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pwg_pkg::SAMPLE_W-1:0]    sample_value,
  output logic                            period_last,
  output logic                            tone_valid
);
  import pwg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RCALC = 7'b0000010,
    S_RWAIT = 7'b0000100,
    S_PHASE = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  localparam int PW = PHASE_W + 2;

  state_t state;

  logic [CFG_W-1:0]    sample_rate_hz;
  logic [CFG_W-1:0]    tone_frequency_hz;
  wave_t               waveform_kind;
  logic [PHASE_W-1:0]  phase_index;
  logic [PHASE_W-1:0]  period_samples;
  logic                period_known;

  logic                restart;
  logic [PHASE_W-1:0]  i_cur;
  logic                last_cur;
  logic                add_mid;
  logic [SAMPLE_W-1:0] res_value;
  logic                res_last;
  logic                res_valid;

  logic                div_start;
  logic [DVD_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_divisor;
  logic                div_done;
  logic [DVD_W-1:0]    div_quotient;

  logic                cfg_hit;
  logic                known_now;
  logic [PHASE_W-1:0]  i_sel;
  logic [PW-1:0]       i_ext;
  logic [PW-1:0]       p_ext;
  logic [PW-1:0]       i2;
  logic [PW-1:0]       i4;
  logic [PW-1:0]       p3;
  logic [DVD_W-1:0]    i_w;
  logic [DVD_W-1:0]    p_w;
  logic [DVD_W-1:0]    load_dividend;
  logic                load_add_mid;
  logic [DIV_W-1:0]    quo_cfg;
  logic [PHASE_W-1:0]  period_clamped;

  logic [SINE_AW+1:0]  sine_a;
  logic [SINE_AW-1:0]  sine_r;
  logic [SINE_AW:0]    rom_idx;
  logic [SINE_VAL_W-1:0] sine_e;
  logic [SAMPLE_W-1:0] wave_result;
  logic                out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign cfg_hit  = cfg_write_en && (cfg_index == REG_SAMPLE_RATE ||
                    cfg_index == REG_TONE_FREQ || cfg_index == REG_WAVEFORM);
  assign known_now = (sample_rate_hz >= CFG_W'(2 * MIN_TONE_HZ)) &&
                     (tone_frequency_hz >= CFG_W'(MIN_TONE_HZ));

  // Period clamp: a zero quotient becomes one, a large one saturates.
  always_comb begin
    quo_cfg = div_quotient[DIV_W-1:0];
    if (quo_cfg == '0) begin
      period_clamped = PHASE_W'(1);
    end else if (quo_cfg > DIV_W'(PERIOD_MAX)) begin
      period_clamped = PHASE_W'(PERIOD_MAX);
    end else begin
      period_clamped = quo_cfg[PHASE_W-1:0];
    end
  end

  assign i_sel = (restart || phase_index >= period_samples) ? '0 : phase_index;

  assign i_ext = {2'b00, i_cur};
  assign p_ext = {2'b00, period_samples};
  assign i2    = {1'b0, i_cur, 1'b0};
  assign i4    = {i_cur, 2'b00};
  assign p3    = p_ext + {p_ext[PW-2:0], 1'b0};
  assign i_w   = DVD_W'(i_ext);
  assign p_w   = DVD_W'(p_ext);

  // Dividends: the sine phase and the ramp numerators, each nonnegative on its segment.
  always_comb begin
    load_dividend = '0;
    load_add_mid  = 1'b0;
    case (waveform_kind)
      WAVE_SINE: begin
        load_dividend = DVD_W'({i_cur, {(SINE_AW + 2){1'b0}}});
      end
      WAVE_TRIANGLE: begin
        if (i4 <= p_ext) begin
          load_dividend = i_w * DVD_W'(508);
          load_add_mid  = 1'b1;
        end else if (i4 <= p3) begin
          load_dividend = p_w * DVD_W'(382) - i_w * DVD_W'(508);
        end else begin
          load_dividend = i_w * DVD_W'(508) - p_w * DVD_W'(380);
        end
      end
      WAVE_SAW: begin
        if (i2 <= p_ext) begin
          load_dividend = i_w * DVD_W'(254);
          load_add_mid  = 1'b1;
        end else begin
          load_dividend = i_w * DVD_W'(254) - p_w * DVD_W'(126);
        end
      end
      default: begin
        load_dividend = '0;
      end
    endcase
  end

  // Quarter-wave sine (odd quadrants mirror, top half negates); ramps may add midscale.
  always_comb begin
    sine_a  = div_quotient[SINE_AW+1:0];
    sine_r  = sine_a[SINE_AW-1:0];
    rom_idx = sine_a[SINE_AW] ? ((SINE_AW + 1)'(SINE_DEPTH) - {1'b0, sine_r})
                              : {1'b0, sine_r};
    sine_e  = SINE_ROM[rom_idx];
    if (waveform_kind == WAVE_SINE) begin
      wave_result = sine_a[SINE_AW+1] ? (SAMPLE_W'(MIDSCALE) - SAMPLE_W'(sine_e))
                                      : (SAMPLE_W'(MIDSCALE) + SAMPLE_W'(sine_e));
    end else if (add_mid) begin
      wave_result = div_quotient[SAMPLE_W-1:0] + SAMPLE_W'(MIDSCALE);
    end else begin
      wave_result = div_quotient[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = load_dividend;
    div_divisor  = DIV_W'(period_samples);
    if (state == S_RCALC) begin
      div_start    = known_now;
      div_dividend = DVD_W'(sample_rate_hz);
      div_divisor  = tone_frequency_hz;
    end else if (state == S_LOAD) begin
      div_start = (waveform_kind != WAVE_SQUARE);
    end
  end

  pwg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      sample_rate_hz    <= '0;
      tone_frequency_hz <= '0;
      waveform_kind     <= WAVE_SINE;
      phase_index       <= '0;
      period_samples    <= '0;
      period_known      <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_hit) begin
        case (cfg_index)
          REG_SAMPLE_RATE: sample_rate_hz    <= cfg_data;
          REG_TONE_FREQ:   tone_frequency_hz <= cfg_data;
          REG_WAVEFORM:    waveform_kind     <= wave_t'(cfg_data[1:0]);
          default:         ;
        endcase
        phase_index <= '0;
        state       <= S_RCALC;
      end else begin
        case (state)
          S_IDLE: begin
            if (in_valid) begin
              state <= S_PHASE;
            end
          end
          S_RCALC: begin
            period_known <= known_now;
            if (known_now) begin
              state <= S_RWAIT;
            end else begin
              period_samples <= '0;
              state          <= S_IDLE;
            end
          end
          S_RWAIT: begin
            if (div_done) begin
              period_samples <= period_clamped;
              state          <= S_IDLE;
            end
          end
          S_PHASE: begin
            if (!period_known || period_samples == '0) begin
              phase_index <= '0;
              state       <= S_OUT;
            end else begin
              if (i_sel == period_samples - 1'b1) begin
                phase_index <= '0;
              end else begin
                phase_index <= i_sel + 1'b1;
              end
              state <= S_LOAD;
            end
          end
          S_LOAD: begin
            state <= (waveform_kind == WAVE_SQUARE) ? S_OUT : S_DIV;
          end
          S_DIV: begin
            if (div_done) begin
              state <= S_OUT;
            end
          end
          S_OUT: begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // Payload registers of the item in flight and of the output stage.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      restart <= restart_phase;
    end
    case (state)
      S_PHASE: begin
        i_cur     <= i_sel;
        last_cur  <= (i_sel == period_samples - 1'b1);
        res_value <= SAMPLE_W'(MIDSCALE);
        res_last  <= 1'b0;
        res_valid <= 1'b0;
      end
      S_LOAD: begin
        add_mid   <= load_add_mid;
        res_last  <= last_cur;
        res_valid <= 1'b1;
        res_value <= (i2 <= p_ext) ? {SAMPLE_W{1'b1}} : '0;
      end
      S_DIV: begin
        if (div_done) begin
          res_value <= wave_result;
        end
      end
      S_OUT: begin
        if (out_free) begin
          sample_value <= res_value;
          period_last  <= res_last;
          tone_valid   <= res_valid;
        end
      end
      default: ;
    endcase
  end

endmodule
